[rtl/teg_pkg.sv]
// Shared types, constants and helper functions for the touch event generator.
`timescale 1ns / 1ps

package teg_pkg;

    // Coordinate width of the raw and placed points.
    localparam int COORD_BITS = 12;

    // Fixed widths of registers and fields.
    localparam int OFF_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int THR_W   = 8;
    localparam int PRESS_W = 8;
    localparam int STR_W   = 16;
    localparam int EV_W    = 3;

    // Width of the offset sum and of the clamp comparison.
    localparam int SUM_W = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 2;
    localparam int CMP_W = (SUM_W > SIZE_W) ? SUM_W : SIZE_W;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
    localparam logic [PRESS_W-1:0]    PRESS_MAX = 8'd255;

    // Register reset values.
    localparam logic [OFF_W-1:0]  RST_OFFSET_X = '0;
    localparam logic [OFF_W-1:0]  RST_OFFSET_Y = '0;
    localparam logic [SIZE_W-1:0] RST_WIDTH    = 13'd240;
    localparam logic [SIZE_W-1:0] RST_HEIGHT   = 13'd280;
    localparam logic [THR_W-1:0]  RST_MOVE_THR = 8'd2;

    typedef enum logic [EV_W-1:0] {
        EV_NONE  = 3'd0,
        EV_DOWN  = 3'd1,
        EV_MOVE  = 3'd2,
        EV_UP    = 3'd3,
        EV_RDERR = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_WIDTH    = 3'd2,
        REG_HEIGHT   = 3'd3,
        REG_MOVE_THR = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [OFF_W-1:0] x_shift;
        logic signed [OFF_W-1:0] y_shift;
        logic [SIZE_W-1:0]       x_extent;
        logic [SIZE_W-1:0]       y_extent;
        logic [THR_W-1:0]        jitter_limit;
    } t_cfg;

    // One classified poll, as it travels from the front end to the back end.
    typedef struct packed {
        logic                  read_ok;
        logic                  point_present;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [PRESS_W-1:0]    pressure;
    } t_cmd;

    // Adds the signed offset and clamps to 0..size-1, never above COORD_MAX.
    function automatic logic [COORD_BITS-1:0] place(
        input logic [COORD_BITS-1:0]   raw,
        input logic signed [OFF_W-1:0] off,
        input logic [SIZE_W-1:0]       size
    );
        logic signed [SUM_W-1:0] sum;
        logic [CMP_W-1:0]        hi;
        logic [CMP_W-1:0]        mag;
        sum = $signed(SUM_W'(raw)) + $signed({{(SUM_W-OFF_W){off[OFF_W-1]}}, off});
        hi  = CMP_W'(size) - CMP_W'(1);
        if (hi > CMP_W'(COORD_MAX)) begin
            hi = CMP_W'(COORD_MAX);
        end
        mag = CMP_W'(sum[SUM_W-2:0]);
        if (sum[SUM_W-1] || (size == '0)) begin
            place = '0;
        end else if (mag > hi) begin
            place = hi[COORD_BITS-1:0];
        end else begin
            place = mag[COORD_BITS-1:0];
        end
    endfunction

    // Saturates the raw strength to the pressure range.
    function automatic logic [PRESS_W-1:0] sat_pressure(input logic [STR_W-1:0] s);
        if (s > STR_W'(PRESS_MAX)) begin
            sat_pressure = PRESS_MAX;
        end else begin
            sat_pressure = s[PRESS_W-1:0];
        end
    endfunction

endpackage

[rtl/teg_if.sv]
// Handshake interfaces for the poll input channel and the event output channel.
`timescale 1ns / 1ps

interface teg_poll_if
    import teg_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  read_ok;
    logic                  point_present;
    logic [COORD_BITS-1:0] raw_x;
    logic [COORD_BITS-1:0] raw_y;
    logic [STR_W-1:0]      strength;

    modport source (output valid, read_ok, point_present, raw_x, raw_y, strength,
                    input ready);
    modport sink   (input valid, read_ok, point_present, raw_x, raw_y, strength,
                    output ready);
endinterface

interface teg_event_if
    import teg_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [EV_W-1:0]       event_res;
    logic                  pressed;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic [PRESS_W-1:0]    point_pressure;
    logic [COORD_BITS-1:0] from_x;
    logic [COORD_BITS-1:0] from_y;
    logic [PRESS_W-1:0]    from_pressure;

    modport source (output valid, event_res, pressed, point_x, point_y, point_pressure,
                    from_x, from_y, from_pressure, input ready);
    modport sink   (input valid, event_res, pressed, point_x, point_y, point_pressure,
                    from_x, from_y, from_pressure, output ready);
endinterface

[rtl/teg_regs.sv]
// APB-style configuration register bank.
`timescale 1ns / 1ps

module teg_regs
    import teg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_shift      <= RST_OFFSET_X;
            r_cfg.y_shift      <= RST_OFFSET_Y;
            r_cfg.x_extent     <= RST_WIDTH;
            r_cfg.y_extent     <= RST_HEIGHT;
            r_cfg.jitter_limit <= RST_MOVE_THR;
        end else if (w_wr) begin
            case (w_idx)
                REG_OFFSET_X: r_cfg.x_shift      <= pwdata[OFF_W-1:0];
                REG_OFFSET_Y: r_cfg.y_shift      <= pwdata[OFF_W-1:0];
                REG_WIDTH:    r_cfg.x_extent     <= pwdata[SIZE_W-1:0];
                REG_HEIGHT:   r_cfg.y_extent     <= pwdata[SIZE_W-1:0];
                REG_MOVE_THR: r_cfg.jitter_limit <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (w_idx)
            REG_OFFSET_X: prdata = DATA_W'($unsigned(r_cfg.x_shift));
            REG_OFFSET_Y: prdata = DATA_W'($unsigned(r_cfg.y_shift));
            REG_WIDTH:    prdata = DATA_W'(r_cfg.x_extent);
            REG_HEIGHT:   prdata = DATA_W'(r_cfg.y_extent);
            REG_MOVE_THR: prdata = DATA_W'(r_cfg.jitter_limit);
            default:      prdata = '0;
        endcase
    end

endmodule

[rtl/teg_front.sv]
// Front end: accepts poll beats, places the point and saturates the pressure.
`timescale 1ns / 1ps

module teg_front
    import teg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    teg_poll_if.sink i_poll,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_ready
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic w_take;

    // The stage takes a new beat whenever it is empty or is handing its beat on.
    assign i_poll.ready = !r_valid || i_ready;
    assign w_take       = i_poll.valid && i_poll.ready;
    assign o_valid      = r_valid;
    assign o_cmd        = r_cmd;

    // Classify the poll: placement and pressure do not depend on touch state.
    always_comb begin
        n_cmd.read_ok       = i_poll.read_ok;
        n_cmd.point_present = i_poll.point_present;
        n_cmd.x             = place(i_poll.raw_x, i_cfg.x_shift, i_cfg.x_extent);
        n_cmd.y             = place(i_poll.raw_y, i_cfg.y_shift, i_cfg.y_extent);
        n_cmd.pressure      = sat_pressure(i_poll.strength);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[rtl/teg_fifo.sv]
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module teg_fifo
    import teg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop_ready
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue fill level out of range");
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 || r_count == 2'd0) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with fill level");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("queue push without fill level change");
`endif

endmodule

[rtl/teg_back.sv]
// Back end: keeps touch state and last point, and forms the event beat.
`timescale 1ns / 1ps

module teg_back
    import teg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_ready,
    teg_event_if.source o_event
);

    logic                  r_touched;
    logic [COORD_BITS-1:0] r_last_x;
    logic [COORD_BITS-1:0] r_last_y;
    logic [PRESS_W-1:0]    r_last_p;

    logic                  r_out_valid;
    t_event                r_ev;
    logic                  r_pressed;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic [PRESS_W-1:0]    r_pp;
    logic [COORD_BITS-1:0] r_fx;
    logic [COORD_BITS-1:0] r_fy;
    logic [PRESS_W-1:0]    r_fp;

    t_event                n_ev;
    logic                  n_touched;
    logic [COORD_BITS-1:0] n_px;
    logic [COORD_BITS-1:0] n_py;
    logic [PRESS_W-1:0]    n_pp;
    logic [COORD_BITS-1:0] n_fx;
    logic [COORD_BITS-1:0] n_fy;
    logic [PRESS_W-1:0]    n_fp;
    logic [COORD_BITS-1:0] w_dx;
    logic [COORD_BITS-1:0] w_dy;
    logic                  w_moved;
    logic                  w_pop;

    // The output register is refilled when empty or when its beat is taken.
    assign o_ready = !r_out_valid || o_event.ready;
    assign w_pop   = i_valid && o_ready;

    // Per-axis distance from the last point.
    assign w_dx    = (i_cmd.x > r_last_x) ? (i_cmd.x - r_last_x) : (r_last_x - i_cmd.x);
    assign w_dy    = (i_cmd.y > r_last_y) ? (i_cmd.y - r_last_y) : (r_last_y - i_cmd.y);
    assign w_moved = (w_dx > COORD_BITS'(i_cfg.jitter_limit)) ||
                     (w_dy > COORD_BITS'(i_cfg.jitter_limit));

    // Event decision against the stored touch state.
    always_comb begin
        n_ev      = EV_NONE;
        n_touched = r_touched;
        n_px      = r_last_x;
        n_py      = r_last_y;
        n_pp      = r_last_p;
        n_fx      = '0;
        n_fy      = '0;
        n_fp      = '0;
        if (!i_cmd.read_ok) begin
            if (r_touched) begin
                n_ev = EV_RDERR;
            end
            n_touched = 1'b0;
        end else if (i_cmd.point_present) begin
            n_px      = i_cmd.x;
            n_py      = i_cmd.y;
            n_pp      = i_cmd.pressure;
            n_touched = 1'b1;
            if (!r_touched) begin
                n_ev = EV_DOWN;
            end else if (w_moved) begin
                n_ev = EV_MOVE;
                n_fx = r_last_x;
                n_fy = r_last_y;
                n_fp = r_last_p;
            end
        end else begin
            if (r_touched) begin
                n_ev = EV_UP;
            end
            n_touched = 1'b0;
        end
    end

    // Touch state and last point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touched <= 1'b0;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_last_p  <= '0;
        end else if (w_pop) begin
            r_touched <= n_touched;
            r_last_x  <= n_px;
            r_last_y  <= n_py;
            r_last_p  <= n_pp;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_ev      <= n_ev;
            r_pressed <= n_touched;
            r_px      <= n_px;
            r_py      <= n_py;
            r_pp      <= n_pp;
            r_fx      <= n_fx;
            r_fy      <= n_fy;
            r_fp      <= n_fp;
        end
    end

    assign o_event.valid          = r_out_valid;
    assign o_event.event_res      = r_ev;
    assign o_event.pressed        = r_pressed;
    assign o_event.point_x        = r_px;
    assign o_event.point_y        = r_py;
    assign o_event.point_pressure = r_pp;
    assign o_event.from_x         = r_fx;
    assign o_event.from_y         = r_fy;
    assign o_event.from_pressure  = r_fp;

`ifndef SYNTHESIS
    a_press_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_ev == EV_DOWN || r_ev == EV_MOVE)) |-> r_pressed)
        else $error("down or move beat without pressed");
    a_release_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_ev == EV_UP || r_ev == EV_RDERR)) |-> !r_pressed)
        else $error("release beat still pressed");
    a_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ev != EV_MOVE) |-> (r_fx == '0 && r_fy == '0 && r_fp == '0))
        else $error("previous point set on a non-move beat");
`endif

endmodule

[rtl/touch_event_generator.sv]
// Top level of the touch event generator: register bank, front end, queue, back end.
`timescale 1ns / 1ps

// Usage
// Each beat on i_poll is one poll of the touch controller: read status,
// point-present flag, raw coordinates and strength. Each poll yields exactly
// one beat on o_event carrying the event code (none, down, move, up or
// release on read error), the pressed state and the current and previous
// points. Both channels use valid/ready; a beat moves when both are high.
// An accepted poll passes three registers: the front-end placement stage,
// the two-entry queue and the back-end output register. A poll can be
// accepted every cycle while the receiver keeps ready high, so the sustained
// rate is one beat per cycle, set by the state update in the back end.
// When the receiver stalls, the output register holds its beat, the queue
// fills and then the front end drops ready; nothing is lost or repeated.
// The APB-style port writes the offsets, display size and move threshold
// at byte address 4*index; it should only be written while the block is idle.
// Synchronous reset clears the touch state, the last point and all queues,
// and loads the register reset values.

module touch_event_generator
    import teg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    teg_poll_if.sink          i_poll,
    teg_event_if.source       o_event
);

    t_cfg w_cfg;
    logic w_f_valid;
    t_cmd w_f_cmd;
    logic w_f_ready;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_ready;

    teg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    teg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_poll  (i_poll),
        .o_valid (w_f_valid),
        .o_cmd   (w_f_cmd),
        .i_ready (w_f_ready)
    );

    teg_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .i_push_cmd   (w_f_cmd),
        .o_push_ready (w_f_ready),
        .o_pop_valid  (w_q_valid),
        .o_pop_cmd    (w_q_cmd),
        .i_pop_ready  (w_q_ready)
    );

    teg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_q_valid),
        .i_cmd   (w_q_cmd),
        .o_ready (w_q_ready),
        .o_event (o_event)
    );

endmodule

[verif/teg_checker.sv]
// Checker for the touch event generator: tracks the touch state and compares every event beat.
`timescale 1ns / 1ps

module teg_checker
    import teg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    teg_poll_if               i_poll,
    teg_event_if              i_event,
    output int                o_fail_count,
    output int                o_outstanding
);

    typedef struct packed {
        t_event                event_res;
        logic                  pressed;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [PRESS_W-1:0]    point_pressure;
        logic [COORD_BITS-1:0] from_x;
        logic [COORD_BITS-1:0] from_y;
        logic [PRESS_W-1:0]    from_pressure;
    } t_touch_event;

    // Shadow copy of the registers and of the touch tracking state.
    t_cfg                  cfg;
    logic                  touched;
    logic [COORD_BITS-1:0] last_x;
    logic [COORD_BITS-1:0] last_y;
    logic [PRESS_W-1:0]    last_pressure;

    // Events predicted for accepted polls, oldest first.
    t_touch_event pending_events[$];

    // Adds the signed offset, then clamps to the display and to the coordinate range.
    function automatic logic [COORD_BITS-1:0] clamp_to_display(
        input logic [COORD_BITS-1:0]   raw,
        input logic signed [OFF_W-1:0] off,
        input logic [SIZE_W-1:0]       size
    );
        int pos;
        int edge_pos;
        pos      = int'(raw) + int'(off);
        edge_pos = int'(size) - 1;
        if (edge_pos > int'(COORD_MAX)) begin
            edge_pos = int'(COORD_MAX);
        end
        if (pos > edge_pos) begin
            pos = edge_pos;
        end
        if (pos < 0) begin
            pos = 0;
        end
        return COORD_BITS'(pos);
    endfunction

    // Works out the event for one poll and advances the touch state.
    function automatic t_touch_event track_touch(
        input logic                  rd_ok,
        input logic                  present,
        input logic [COORD_BITS-1:0] raw_x,
        input logic [COORD_BITS-1:0] raw_y,
        input logic [STR_W-1:0]      strength
    );
        t_touch_event res;
        int           dx;
        int           dy;
        res.event_res      = EV_NONE;
        res.point_x        = last_x;
        res.point_y        = last_y;
        res.point_pressure = last_pressure;
        res.from_x         = '0;
        res.from_y         = '0;
        res.from_pressure  = '0;
        if (!rd_ok) begin
            // A failed read ends a touch without a normal release.
            if (touched) begin
                res.event_res = EV_RDERR;
            end
            touched = 1'b0;
        end else if (present) begin
            res.point_x = clamp_to_display(raw_x, cfg.x_shift, cfg.x_extent);
            res.point_y = clamp_to_display(raw_y, cfg.y_shift, cfg.y_extent);
            res.point_pressure = (strength > STR_W'(PRESS_MAX)) ? PRESS_MAX
                                                                : strength[PRESS_W-1:0];
            dx = int'(res.point_x) - int'(last_x);
            dy = int'(res.point_y) - int'(last_y);
            if (dx < 0) begin
                dx = -dx;
            end
            if (dy < 0) begin
                dy = -dy;
            end
            if (!touched) begin
                res.event_res = EV_DOWN;
            end else if (dx > int'(cfg.jitter_limit) || dy > int'(cfg.jitter_limit)) begin
                res.event_res     = EV_MOVE;
                res.from_x        = last_x;
                res.from_y        = last_y;
                res.from_pressure = last_pressure;
            end
            // The last point follows every touched poll, moved or not.
            last_x        = res.point_x;
            last_y        = res.point_y;
            last_pressure = res.point_pressure;
            touched       = 1'b1;
        end else begin
            if (touched) begin
                res.event_res = EV_UP;
            end
            touched = 1'b0;
        end
        res.pressed = touched;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    // Everything is sampled at the rising edge, before the block updates its outputs.
    always @(posedge i_clk) begin
        t_touch_event want;
        if (!i_rst_n) begin
            cfg.x_shift        = RST_OFFSET_X;
            cfg.y_shift        = RST_OFFSET_Y;
            cfg.x_extent       = RST_WIDTH;
            cfg.y_extent       = RST_HEIGHT;
            cfg.jitter_limit   = RST_MOVE_THR;
            touched            = 1'b0;
            last_x             = '0;
            last_y             = '0;
            last_pressure      = '0;
            pending_events.delete();
            o_fail_count       = 0;
        end else begin
            // Register writes land at the access cycle.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[ADDR_W-1:2]))
                    REG_OFFSET_X: cfg.x_shift      = i_pwdata[OFF_W-1:0];
                    REG_OFFSET_Y: cfg.y_shift      = i_pwdata[OFF_W-1:0];
                    REG_WIDTH:    cfg.x_extent     = i_pwdata[SIZE_W-1:0];
                    REG_HEIGHT:   cfg.y_extent     = i_pwdata[SIZE_W-1:0];
                    REG_MOVE_THR: cfg.jitter_limit = i_pwdata[THR_W-1:0];
                    default: ;
                endcase
            end

            // An event beat is matched against the oldest prediction.
            if (i_event.valid && i_event.ready) begin
                if (pending_events.size() == 0) begin
                    $error("event beat arrived with no poll awaiting its event");
                    o_fail_count++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_res", want.event_res, i_event.event_res);
                    check_field("pressed", want.pressed, i_event.pressed);
                    check_field("point_x", want.point_x, i_event.point_x);
                    check_field("point_y", want.point_y, i_event.point_y);
                    check_field("point_pressure", want.point_pressure,
                                i_event.point_pressure);
                    check_field("from_x", want.from_x, i_event.from_x);
                    check_field("from_y", want.from_y, i_event.from_y);
                    check_field("from_pressure", want.from_pressure,
                                i_event.from_pressure);
                end
            end

            // Each accepted poll produces exactly one event.
            if (i_poll.valid && i_poll.ready) begin
                pending_events.push_back(track_touch(i_poll.read_ok, i_poll.point_present,
                                                     i_poll.raw_x, i_poll.raw_y,
                                                     i_poll.strength));
            end
        end
        o_outstanding = pending_events.size();
    end

endmodule

[verif/tb_touch_event_generator.sv]
// Testbench top for the touch event generator: clock, reset, poll stimulus and verdict.
`timescale 1ns / 1ps

module tb_touch_event_generator;
    import teg_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int PHASE_POLLS    = 200;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 4000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int outstanding;
    int polls_sent     = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cur_thr        = int'(RST_MOVE_THR);
    int quiet_cycles   = 0;
    bit hold_go        = 1'b0;

    teg_poll_if  poll_bus ();
    teg_event_if event_bus ();

    touch_event_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_poll  (poll_bus),
        .o_event (event_bus)
    );

    teg_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_poll        (poll_bus),
        .i_event       (event_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : receiver
        event_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                event_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            event_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // The run is abandoned when nothing has moved for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((poll_bus.valid && poll_bus.ready) || (event_bus.valid && event_bus.ready)
                || psel) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one poll, idling first at the current rate; returns once the beat is taken.
    task automatic send_poll(input logic rd_ok, input logic present,
                             input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                             input logic [STR_W-1:0] strength);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            poll_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        poll_bus.valid         <= 1'b1;
        poll_bus.read_ok       <= rd_ok;
        poll_bus.point_present <= present;
        poll_bus.raw_x         <= x;
        poll_bus.raw_y         <= y;
        poll_bus.strength      <= strength;
        do @(posedge i_clk); while (!poll_bus.ready);
        polls_sent++;
    endtask

    // Stops offering polls and waits until every event has come back.
    task automatic drain_events();
        @(negedge i_clk);
        poll_bus.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers are only rewritten once the block has gone idle.
    task automatic write_config(input int off_x, input int off_y, input int width,
                                input int height, input int thr);
        drain_events();
        apb_write(REG_OFFSET_X, DATA_W'(off_x));
        apb_write(REG_OFFSET_Y, DATA_W'(off_y));
        apb_write(REG_WIDTH, DATA_W'(width));
        apb_write(REG_HEIGHT, DATA_W'(height));
        apb_write(REG_MOVE_THR, DATA_W'(thr));
        cur_thr = thr;
    endtask

    function automatic int rand_offset();
        case ($urandom_range(9))
            0:          return -2048;
            1:          return 2047;
            2, 3, 4, 5: return int'($urandom_range(100)) - 50;
            default:    return int'($urandom_range(4095)) - 2048;
        endcase
    endfunction

    // Mostly ordinary display sizes, sometimes zero or beyond the coordinate range.
    function automatic int rand_size();
        case ($urandom_range(9))
            0:       return 0;
            1:       return int'($urandom_range(8191, 4097));
            2:       return 4096;
            3:       return 1;
            default: return int'($urandom_range(800, 64));
        endcase
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 4095;
            2, 3:    return int'($urandom_range(4095));
            default: return int'($urandom_range(900));
        endcase
    endfunction

    function automatic logic [STR_W-1:0] rand_strength();
        case ($urandom_range(3))
            0:       return STR_W'($urandom_range(255));
            1:       return STR_W'($urandom_range(65535));
            2:       return STR_W'($urandom_range(256, 254));
            default: return STR_W'($urandom_range(300));
        endcase
    endfunction

    // A touch: down, a few jittered points around the threshold, then mostly a release or a failed read.
    task automatic send_gesture();
        int steps;
        int span;
        int gx;
        int gy;
        int ending;
        steps = $urandom_range(8, 1);
        span  = cur_thr + 2;
        gx    = rand_coord();
        gy    = rand_coord();
        for (int i = 0; i < steps; i++) begin
            send_poll(1'b1, 1'b1, COORD_BITS'(gx), COORD_BITS'(gy), rand_strength());
            gx += int'($urandom_range(2 * span)) - span;
            gy += int'($urandom_range(2 * span)) - span;
        end
        ending = $urandom_range(99);
        if (ending < 70) begin
            send_poll(1'b1, 1'b0, COORD_BITS'($urandom_range(4095)),
                      COORD_BITS'($urandom_range(4095)), STR_W'($urandom_range(65535)));
        end else if (ending < 90) begin
            send_poll(1'b0, 1'($urandom_range(1)), COORD_BITS'($urandom_range(4095)),
                      COORD_BITS'($urandom_range(4095)), STR_W'($urandom_range(65535)));
        end
    endtask

    initial begin : stimulus
        int base;
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        poll_bus.valid         = 1'b0;
        poll_bus.read_ok       = 1'b0;
        poll_bus.point_present = 1'b0;
        poll_bus.raw_x         = '0;
        poll_bus.raw_y         = '0;
        poll_bus.strength      = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: idle polls, then a touch that crosses the threshold and lets go.
        send_poll(1'b0, 1'b1, 12'd5, 12'd5, 16'd9);
        send_poll(1'b1, 1'b0, 12'd7, 12'd7, 16'd0);
        send_poll(1'b1, 1'b1, 12'd0, 12'd0, 16'd0);
        send_poll(1'b1, 1'b1, 12'd2, 12'd2, 16'd255);
        send_poll(1'b1, 1'b1, 12'd5, 12'd2, 16'd255);
        send_poll(1'b1, 1'b1, 12'd5, 12'd5, 16'd256);
        send_poll(1'b1, 1'b1, 12'd4095, 12'd4095, 16'd65535);
        send_poll(1'b1, 1'b0, 12'd0, 12'd0, 16'd0);
        send_poll(1'b1, 1'b0, 12'd4095, 12'd4095, 16'd65535);
        send_poll(1'b1, 1'b1, 12'd100, 12'd200, 16'd17);
        // A failed read during a touch, with junk in the point fields.
        send_poll(1'b0, 1'b1, 12'd4095, 12'd4095, 16'd65535);
        send_poll(1'b0, 1'b0, 12'd0, 12'd0, 16'd0);

        // Zero display size with the most negative and most positive offsets.
        write_config(-2048, 2047, 0, 0, 0);
        send_poll(1'b1, 1'b1, 12'd4095, 12'd4095, 16'd1000);
        send_poll(1'b1, 1'b1, 12'd0, 12'd0, 16'd1);
        send_poll(1'b1, 1'b0, 12'd0, 12'd0, 16'd0);

        // Sizes beyond the coordinate range saturate; largest threshold.
        write_config(2047, -2048, 8191, 4096, 255);
        send_poll(1'b1, 1'b1, 12'd4095, 12'd0, 16'd128);
        send_poll(1'b1, 1'b1, 12'd0, 12'd4095, 16'd300);
        send_poll(1'b1, 1'b1, 12'd1, 12'd4095, 16'd2);
        send_poll(1'b0, 1'b0, 12'd0, 12'd0, 16'd0);

        // Zero threshold: a one-step change is already a move.
        write_config(0, 0, 4096, 1, 0);
        send_poll(1'b1, 1'b1, 12'd10, 12'd4095, 16'd40);
        send_poll(1'b1, 1'b1, 12'd11, 12'd4095, 16'd41);
        send_poll(1'b1, 1'b0, 12'd0, 12'd0, 16'd0);

        // Random phases, each with fresh settings and its own idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            write_config(rand_offset(), rand_offset(), rand_size(), rand_size(),
                         ($urandom_range(7) == 0) ? 255 : int'($urandom_range(12)));
            case (ph)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    hold_go        = 1'b1;
                end
                1: begin
                    src_idle_pct   = 81;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 81;
                end
                default: begin
                    src_idle_pct   = 33;
                    sink_stall_pct = 33;
                end
            endcase
            base = polls_sent;
            while (polls_sent - base < PHASE_POLLS) begin
                if ($urandom_range(99) < 75) begin
                    send_gesture();
                end else begin
                    send_poll(1'($urandom_range(1)), 1'($urandom_range(1)),
                              COORD_BITS'($urandom_range(4095)),
                              COORD_BITS'($urandom_range(4095)),
                              STR_W'($urandom_range(65535)));
                end
            end
        end

        // Let the last events come out and give stray beats a chance to show.
        drain_events();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/teg_pkg.sv
rtl/teg_if.sv
rtl/teg_regs.sv
rtl/teg_front.sv
rtl/teg_fifo.sv
rtl/teg_back.sv
rtl/touch_event_generator.sv
verif/teg_checker.sv
verif/tb_touch_event_generator.sv
